@@ rtl/black_pixel_centroid_defines.svh @@
// Assertion macros for the black pixel centroid RTL.
`ifndef BLACK_PIXEL_CENTROID_DEFINES_SVH
`define BLACK_PIXEL_CENTROID_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("black_pixel_centroid: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("black_pixel_centroid: next-cycle check failed");

`endif

@@ rtl/bpc_pkg.sv @@
// Shared constants, codes and types of the black pixel centroid block.
`default_nettype none
package bpc_pkg;

   localparam int MAX_DIM = 4096;
   localparam int POS_W   = $clog2(MAX_DIM);        // column / row position
   localparam int DIM_W   = POS_W + 1;              // clamped frame size
   localparam int CFG_W   = 13;                     // size register width
   localparam int PIX_W   = 8;
   localparam int CNT_W   = 2 * POS_W + 1;          // black pixel count
   localparam int SUM_W   = CNT_W - 1 + POS_W;      // coordinate sums
   localparam int QUOT_W  = POS_W;                  // centroid coordinate
   localparam int STEP_W  = $clog2(QUOT_W);
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic [SUM_W-1:0] sum_x;
      logic [SUM_W-1:0] sum_y;
      logic [CNT_W-1:0] count;
   } frame_sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/bpc_front.sv @@
// Front end: size registers, raster position tracking and per-frame sums.
`default_nettype none
module bpc_front (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_write_enable,
   input  wire [bpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [bpc_pkg::CFG_W-1:0]        csr_write_data,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [bpc_pkg::PIX_W-1:0]        req_pixel_value,
   input  bpc_pkg::queue_status_type       q_status,
   output logic                            push,
   output bpc_pkg::frame_sums_type         push_entry
);
   import bpc_pkg::*;

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic [SUM_W-1:0] sum_y_ff, sum_y_in;

   logic [DIM_W-1:0] w_eff, h_eff, col_plus, row_plus;
   logic             row_end, frame_end, accept, is_black;
   logic [CNT_W-1:0] count_sum;
   logic [SUM_W-1:0] sum_x_sum, sum_y_sum;

   // zero reads as one, oversize saturates
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (frame_width_ff > CFG_W'(MAX_DIM)) begin
         w_eff = DIM_W'(MAX_DIM);
      end else begin
         w_eff = DIM_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (frame_height_ff > CFG_W'(MAX_DIM)) begin
         h_eff = DIM_W'(MAX_DIM);
      end else begin
         h_eff = DIM_W'(frame_height_ff);
      end
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   assign col_plus  = DIM_W'(col_ff) + DIM_W'(1);
   assign row_plus  = DIM_W'(row_ff) + DIM_W'(1);
   assign row_end   = col_plus >= w_eff;
   assign frame_end = row_end && (row_plus >= h_eff);

   // only the closing pixel needs a free queue slot
   assign req_ready = !q_status.full || !frame_end;
   assign accept    = req_valid && req_ready;
   assign is_black  = req_pixel_value == '0;

   assign count_sum = count_ff + CNT_W'(is_black);
   assign sum_x_sum = sum_x_ff + (is_black ? SUM_W'(col_ff) : '0);
   assign sum_y_sum = sum_y_ff + (is_black ? SUM_W'(row_ff) : '0);

   assign push             = accept && frame_end;
   assign push_entry.sum_x = sum_x_sum;
   assign push_entry.sum_y = sum_y_sum;
   assign push_entry.count = count_sum;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      count_in = count_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      if (accept) begin
         if (frame_end) begin
            col_in   = '0;
            row_in   = '0;
            count_in = '0;
            sum_x_in = '0;
            sum_y_in = '0;
         end else begin
            count_in = count_sum;
            sum_x_in = sum_x_sum;
            sum_y_in = sum_y_sum;
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + POS_W'(1);
            end else begin
               col_in = col_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         count_ff        <= '0;
         sum_x_ff        <= '0;
         sum_y_ff        <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         count_ff        <= count_in;
         sum_x_ff        <= sum_x_in;
         sum_y_ff        <= sum_y_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bpc_queue.sv @@
// Two-entry queue of finished frame sums between front and back end.
`default_nettype none
module bpc_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  bpc_pkg::frame_sums_type   push_entry,
   input  wire                       pop,
   output bpc_pkg::frame_sums_type   head,
   output bpc_pkg::queue_status_type status
);
   import bpc_pkg::*;

   frame_sums_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = fill_ff == 2'd2;
   assign status.empty = fill_ff == 2'd0;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bpc_back.sv @@
// Back end: shift-subtract division of both sums and the result register.
`default_nettype none
module bpc_back (
   input  wire                          clock,
   input  wire                          reset,
   input  bpc_pkg::queue_status_type    q_status,
   input  bpc_pkg::frame_sums_type      head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [bpc_pkg::QUOT_W-1:0]   rsp_center_x,
   output logic [bpc_pkg::QUOT_W-1:0]   rsp_center_y,
   output logic [bpc_pkg::CNT_W-1:0]    rsp_black_total,
   output logic                         rsp_empty_frame
);
   import bpc_pkg::*;

   back_state_type    state_ff, state_in;
   logic [SUM_W-1:0]  rem_x_ff, rem_y_ff, div_ff;
   logic [QUOT_W-1:0] quot_x_ff, quot_y_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              empty_ff;
   logic [STEP_W-1:0] step_ff;
   logic              load, divide, fit_x, fit_y;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               state_in = (head.count == '0) ? BACK_DONE : BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (rsp_ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      divide    = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   pop       = !q_status.empty;
         BACK_DIVIDE: divide    = 1'b1;
         BACK_DONE:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign load  = pop;
   assign fit_x = rem_x_ff >= div_ff;
   assign fit_y = rem_y_ff >= div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // quotient fits QUOT_W bits: a mean coordinate stays below MAX_DIM
   always_ff @(posedge clock) begin
      if (load) begin
         rem_x_ff  <= head.sum_x;
         rem_y_ff  <= head.sum_y;
         div_ff    <= SUM_W'(head.count) << (QUOT_W - 1);
         quot_x_ff <= '0;
         quot_y_ff <= '0;
         count_ff  <= head.count;
         empty_ff  <= head.count == '0;
         step_ff   <= STEP_W'(QUOT_W - 1);
      end else if (divide) begin
         if (fit_x) begin
            rem_x_ff <= rem_x_ff - div_ff;
         end
         if (fit_y) begin
            rem_y_ff <= rem_y_ff - div_ff;
         end
         quot_x_ff <= {quot_x_ff[QUOT_W-2:0], fit_x};
         quot_y_ff <= {quot_y_ff[QUOT_W-2:0], fit_y};
         div_ff    <= div_ff >> 1;
         step_ff   <= step_ff - STEP_W'(1);
      end
   end

   assign rsp_center_x    = quot_x_ff;
   assign rsp_center_y    = quot_y_ff;
   assign rsp_black_total = count_ff;
   assign rsp_empty_frame = empty_ff;

endmodule
`default_nettype wire

@@ rtl/black_pixel_centroid.sv @@
// Top level of the black pixel centroid block: front end, queue, divider.
//
// Pixels come in on req_* in raster order, one item per pixel; the block
// keeps column and row itself from frame_width / frame_height (csr index 0
// and 1, zero reads as one, oversize saturates to MAX_DIM). Pixels with
// value zero are counted and their coordinates summed.
// One rsp_* item leaves per frame: black pixel count, truncated mean column
// and row, and empty_frame when no pixel was black (centroid zero).
// Throughput: one pixel per cycle while req_ready is high. The closing pixel of a frame hands its
// sums to a two-entry queue; the back end pops it when idle and runs a
// shift-subtract division, one quotient bit per cycle for the QUOT_W (12) bits.
// An empty frame skips the division and goes straight to the result. The
// back end takes one frame at a time, from pop through division to the result,
// so very small frames are bounded by the divider, not the pixel rate.
// Receiver stall: the result waits in the back end; the front keeps taking
// pixels and only holds req_ready low on a frame's closing pixel while both
// queue entries are taken.
// Reset (synchronous): sizes return to 640 x 480, position and sums clear,
// the queue empties and no result is pending.
`default_nettype none
`include "black_pixel_centroid_defines.svh"
module black_pixel_centroid (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_write_enable,
   input  wire [bpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [bpc_pkg::CFG_W-1:0]     csr_write_data,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [bpc_pkg::PIX_W-1:0]     req_pixel_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [bpc_pkg::QUOT_W-1:0]   rsp_center_x,
   output logic [bpc_pkg::QUOT_W-1:0]   rsp_center_y,
   output logic [bpc_pkg::CNT_W-1:0]    rsp_black_total,
   output logic                         rsp_empty_frame
);
   import bpc_pkg::*;

   queue_status_type q_status;
   frame_sums_type   push_entry, head;
   logic             push, pop;

   // front: size registers, position counters, running sums
   bpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decouples the pixel stream from the divider
   bpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back: division and held result
   bpc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_center_x    (rsp_center_x),
      .rsp_center_y    (rsp_center_y),
      .rsp_black_total (rsp_black_total),
      .rsp_empty_frame (rsp_empty_frame)
   );

   // no push into a full queue unless a pop frees a slot, no pop from an empty one
   `BPC_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !q_status.full || pop)
   `BPC_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, !q_status.empty)
   // empty frame result carries all-zero fields
   `BPC_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_empty_frame,
      rsp_center_x == '0 && rsp_center_y == '0 && rsp_black_total == '0)
   // a non-empty result has a nonzero count
   `BPC_ASSERT_IMPLY(a_count_nonzero, clock, reset, rsp_valid && !rsp_empty_frame,
      rsp_black_total != '0)

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the black pixel centroid block.
module tb;
   import bpc_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int TAIL_ITEMS   = 100;              // final stretch runs with no idling
   localparam int DRAIN_CYCLES = 2 * (2 + QUOT_W); // result latency, with margin

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;
   logic                 req_valid;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [QUOT_W-1:0]    rsp_center_x;
   logic [QUOT_W-1:0]    rsp_center_y;
   logic [CNT_W-1:0]     rsp_black_total;
   logic                 rsp_empty_frame;

   // Random idle bursts on both channels while set.
   bit idle_on;

   typedef struct {
      logic [QUOT_W-1:0] center_x;
      logic [QUOT_W-1:0] center_y;
      logic [CNT_W-1:0]  black_total;
      logic              empty_frame;
   } centroid_result_type;

   // Tracks frame position and black pixel sums, queues the centroid of each
   // closed frame and compares it with what the block sends out.
   class centroid_scoreboard;
      logic [CFG_W-1:0]    width_reg;
      logic [CFG_W-1:0]    height_reg;
      int unsigned         column_pos;
      int unsigned         row_pos;
      longint unsigned     black_count;
      longint unsigned     sum_x;
      longint unsigned     sum_y;
      centroid_result_type pending_results[$];
      int                  error_count;

      function new();
         width_reg   = FRAME_WIDTH_RESET;
         height_reg  = FRAME_HEIGHT_RESET;
         error_count = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         column_pos  = 0;
         row_pos     = 0;
         black_count = 0;
         sum_x       = 0;
         sum_y       = 0;
      endfunction

      // zero reads as one, oversize saturates
      function int unsigned clamp_size(logic [CFG_W-1:0] value);
         if (value == 0) return 1;
         if (value > MAX_DIM) return MAX_DIM;
         return value;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_FRAME_WIDTH) width_reg = value;
         else if (index == CSR_FRAME_HEIGHT) height_reg = value;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] pixel);
         int unsigned         frame_w;
         int unsigned         frame_h;
         bit                  row_end;
         bit                  frame_end;
         centroid_result_type result;
         frame_w = clamp_size(width_reg);
         frame_h = clamp_size(height_reg);
         if (pixel == 0) begin
            black_count++;
            sum_x += column_pos;
            sum_y += row_pos;
         end
         // size takes effect at once: a position past a shrunk size closes now
         row_end   = (column_pos + 1) >= frame_w;
         frame_end = row_end && ((row_pos + 1) >= frame_h);
         if (!frame_end) begin
            if (row_end) begin
               column_pos = 0;
               row_pos++;
            end else begin
               column_pos++;
            end
            return;
         end
         if (black_count == 0) begin
            result.center_x    = '0;
            result.center_y    = '0;
            result.black_total = '0;
            result.empty_frame = 1'b1;
         end else begin
            result.center_x    = QUOT_W'(sum_x / black_count);
            result.center_y    = QUOT_W'(sum_y / black_count);
            result.black_total = CNT_W'(black_count);
            result.empty_frame = 1'b0;
         end
         pending_results.push_back(result);
         clear_frame();
      endfunction

      function void check_result(logic [QUOT_W-1:0] center_x, logic [QUOT_W-1:0] center_y,
                                 logic [CNT_W-1:0] black_total, logic empty_frame);
         centroid_result_type exp_result;
         if (pending_results.size() == 0) begin
            $error("result item with no frame closed: x %0d y %0d total %0d empty %0d",
                   center_x, center_y, black_total, empty_frame);
            error_count++;
            return;
         end
         exp_result = pending_results.pop_front();
         if (center_x !== exp_result.center_x) begin
            $error("center_x: expected %0d, actual %0d", exp_result.center_x, center_x);
            error_count++;
         end
         if (center_y !== exp_result.center_y) begin
            $error("center_y: expected %0d, actual %0d", exp_result.center_y, center_y);
            error_count++;
         end
         if (black_total !== exp_result.black_total) begin
            $error("black_total: expected %0d, actual %0d",
                   exp_result.black_total, black_total);
            error_count++;
         end
         if (empty_frame !== exp_result.empty_frame) begin
            $error("empty_frame: expected %0d, actual %0d",
                   exp_result.empty_frame, empty_frame);
            error_count++;
         end
      endfunction
   endclass

   centroid_scoreboard sb;

   black_pixel_centroid dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_center_x     (rsp_center_x),
      .rsp_center_y     (rsp_center_y),
      .rsp_black_total  (rsp_black_total),
      .rsp_empty_frame  (rsp_empty_frame)
   );

   // 2 ns clock, first rising edge at 1 ns
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Black with the given percentage, else any nonzero grey.
   function automatic logic [PIX_W-1:0] random_pixel(int unsigned black_pct);
      if ($urandom_range(0, 99) < black_pct) return '0;
      return PIX_W'($urandom_range(1, 255));
   endfunction

   // One pixel item; an optional idle burst goes first with valid low.
   // Inputs are read right at the edge, so req_ready is the pre-edge value.
   task automatic send_pixel(input logic [PIX_W-1:0] pixel);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pixel;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_pixel(pixel);
   endtask

   // Enable goes low again before the next write, so it never drops and rises in one step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(index, value);
      @(posedge clock);
   endtask

   // Drop valid, let every closed frame come out, then let the back end go
   // quiet before any register write.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result receiver: ready bursts low at random while idling is on.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Result monitor: sampled at the edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         sb.check_result(rsp_center_x, rsp_center_y, rsp_black_total, rsp_empty_frame);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int          random_count;
      int unsigned black_pct;
      int unsigned phase_len;
      sb               = new();
      idle_on          = 1'b1;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_pixel_value  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: 3 x 2 frames ----
      write_csr(CSR_FRAME_WIDTH, CFG_W'(3));
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(2));
      // mixed frame, low bits walked
      send_pixel(8'h00);
      send_pixel(8'h01);
      send_pixel(8'h02);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h04);
      // frame with no black pixel, upper bits walked
      for (int i = 3; i < PIX_W; i++) send_pixel(PIX_W'(1 << i));
      send_pixel(8'hFF);
      // all black, mean row 0.5 truncates to 0
      repeat (6) send_pixel(8'h00);
      settle();

      // ---- directed: zero sizes read as 1 x 1, each pixel closes a frame ----
      write_csr(CSR_FRAME_WIDTH, CFG_W'(0));
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(0));
      send_pixel(8'h00);
      send_pixel(8'h80);
      settle();

      // ---- directed: shrink the frame while the position is beyond it ----
      write_csr(CSR_FRAME_WIDTH, CFG_W'(5));
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(3));
      repeat (8) send_pixel(random_pixel(50));   // stops at row 1, column 3
      settle();
      write_csr(CSR_FRAME_WIDTH, CFG_W'(2));
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(2));
      send_pixel(8'h00);                         // closes row and frame at once
      settle();

      // ---- largest sizes: oversize width, then exact max height ----
      // Each long row or column is cut short by a later shrink.
      write_csr(CSR_FRAME_WIDTH, CFG_W'(8191));
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(0));
      repeat (12) send_pixel(random_pixel(50));
      settle();
      write_csr(CSR_FRAME_WIDTH, CFG_W'(0));
      send_pixel(8'h00);                         // column 12 closes the frame
      settle();
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(MAX_DIM));
      repeat (10) send_pixel(random_pixel(50));  // one pixel per row
      settle();
      write_csr(CSR_FRAME_HEIGHT, CFG_W'(1));
      send_pixel(8'h00);                         // row 10 closes the frame
      settle();

      // ---- random phases: small frames, phases often end mid-frame ----
      // A rare oversize height keeps a frame open over several phases until a
      // later smaller height closes it at the next row end.
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         idle_on = (random_count < RANDOM_ITEMS - TAIL_ITEMS) ?
                   ($urandom_range(0, 3) != 0) : 1'b0;
         if ($urandom_range(0, 3) != 0)
            write_csr(CSR_FRAME_WIDTH, CFG_W'($urandom_range(0, 6)));
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 7) == 0)
               write_csr(CSR_FRAME_HEIGHT, CFG_W'($urandom_range(0, 8191)));
            else
               write_csr(CSR_FRAME_HEIGHT, CFG_W'($urandom_range(0, 6)));
         end
         case ($urandom_range(0, 3))
            0: begin
               black_pct = 0;
            end
            1: begin
               black_pct = 100;
            end
            default: begin
               black_pct = $urandom_range(1, 99);
            end
         endcase
         phase_len = $urandom_range(4, 40);
         repeat (phase_len) begin
            send_pixel(random_pixel(black_pct));
            random_count++;
         end
         settle();
      end

      if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
